// ----- rtl/lhp_pkg.sv -----
// shared constants, types and edge functions for the log2 histogram percentile block
package lhp_pkg;

   localparam int SLOT_DEPTH = 32;
   localparam int IDX_W      = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);
   localparam int COUNT_W    = 32;
   localparam int EDGE_W     = 32;
   localparam int TOTAL_W    = 37;
   localparam int PCT_W      = 7;
   localparam int SUM_W      = TOTAL_W + PCT_W;
   localparam int N_PCT      = 3;
   localparam int PCT_DIV    = 100;
   localparam int ROUND_UP   = PCT_DIV - 1;

   localparam logic [PCT_W-1:0] PCT_VALUE [N_PCT] = '{7'd50, 7'd95, 7'd99};

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_POST
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic post;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic busy;
      logic rsp_free;
   } sts_type;

   function automatic logic [EDGE_W-1:0] lower_edge(input logic [IDX_W-1:0] idx);
      logic [EDGE_W-1:0] val;
      if (idx == '0) begin
         val = '0;
      end else if (int'(idx) >= EDGE_W) begin
         val = '1;
      end else begin
         val = EDGE_W'(1) << idx;
      end
      return val;
   endfunction

   function automatic logic [EDGE_W-1:0] upper_edge(input logic [IDX_W-1:0] idx);
      logic [EDGE_W-1:0] val;
      if (int'(idx) >= EDGE_W - 1) begin
         val = '1;
      end else begin
         val = (EDGE_W'(2) << idx) - EDGE_W'(1);
      end
      return val;
   endfunction

endpackage

// ----- rtl/log2_histogram_percentiles_top.sv -----
// top level of the log2 histogram percentile block
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_slot_count, req_last_slot
//  rsp      out        rsp_valid/rsp_stall  median, p95, p99 edges, max bound, no_events
//
// one request per cycle while loading; after the last slot the block sets the thresholds,
// reads each stored slot from the slot memory, drains the scan pipeline and then loads
// the result register
// synchronous reset clears the totals, pipeline valids and response valid
// a waiting response holds only the final result step; loading is stalled during scans
module log2_histogram_percentiles_top import lhp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COUNT_W-1:0] req_slot_count,
   input  logic               req_last_slot,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [EDGE_W-1:0]  rsp_median_edge,
   output logic [EDGE_W-1:0]  rsp_p95_edge,
   output logic [EDGE_W-1:0]  rsp_p99_edge,
   output logic [EDGE_W-1:0]  rsp_max_bound,
   output logic               rsp_no_events
);

   cmd_type cmd;
   sts_type sts;

   lhp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_slot (req_last_slot),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   lhp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_slot_count  (req_slot_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median_edge (rsp_median_edge),
      .rsp_p95_edge    (rsp_p95_edge),
      .rsp_p99_edge    (rsp_p99_edge),
      .rsp_max_bound   (rsp_max_bound),
      .rsp_no_events   (rsp_no_events)
   );

   a_post_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.post |=> rsp_valid)
      else $error("result not presented after post");

   a_post_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> !sts.busy)
      else $error("result posted while scan pipeline busy");

   a_no_load_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.load && req_stall)
      else $error("request accepted during scan");

endmodule

// ----- rtl/lhp_ctrl.sv -----
// controller state machine sequencing load, scan, drain and result
module lhp_ctrl import lhp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last_slot,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_slot) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (sts.rsp_free) begin
               cmd.post = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- rtl/lhp_dp.sv -----
// datapath: slot memory, running total, scan pipeline and result register
module lhp_dp import lhp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [COUNT_W-1:0]  req_slot_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EDGE_W-1:0]   rsp_median_edge,
   output logic [EDGE_W-1:0]   rsp_p95_edge,
   output logic [EDGE_W-1:0]   rsp_p99_edge,
   output logic [EDGE_W-1:0]   rsp_max_bound,
   output logic                rsp_no_events
);

   logic [COUNT_W-1:0] slot_mem [SLOT_DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]   s1_idx_ff, s1_idx_in;
   logic [IDX_W-1:0]   s2_idx_ff, s2_idx_in;
   logic [SUM_W-1:0]   cum_ff, cum_in;
   logic [SUM_W-1:0]   pt_ff [N_PCT];
   logic [SUM_W-1:0]   pt_in [N_PCT];
   logic               found_ff [N_PCT];
   logic               found_in [N_PCT];
   logic [EDGE_W-1:0]  edge_ff [N_PCT];
   logic [EDGE_W-1:0]  edge_in [N_PCT];
   logic               max_seen_ff, max_seen_in;
   logic [IDX_W-1:0]   max_idx_ff, max_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [EDGE_W-1:0]  median_ff, p95_ff, p99_ff, max_bound_ff;
   logic               no_events_ff;
   logic               store_ok;

   assign store_ok = cnt_ff < CNT_W'(SLOT_DEPTH);

   // slot memory
   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         slot_mem[cnt_ff[IDX_W-1:0]] <= req_slot_count;
      end
      if (cmd.issue) begin
         rd_data_ff <= slot_mem[addr_ff];
      end
   end

   always_comb begin
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      s1_valid_in  = cmd.issue;
      s1_idx_in    = addr_ff;
      s2_valid_in  = s1_valid_ff;
      s2_idx_in    = s1_idx_ff;
      cum_in       = cum_ff;
      max_seen_in  = max_seen_ff;
      max_idx_in   = max_idx_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.load && store_ok) begin
         total_in = total_ff + TOTAL_W'(req_slot_count);
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      if (cmd.post) begin
         total_in = '0;
         cnt_in   = '0;
      end

      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.issue) begin
         addr_in = addr_ff + IDX_W'(1);
      end

      // cumulative count kept scaled by 100 with the round-up folded in
      if (cmd.start) begin
         cum_in      = SUM_W'(ROUND_UP);
         max_seen_in = 1'b0;
      end else if (s1_valid_ff) begin
         cum_in = cum_ff + SUM_W'(rd_data_ff) * SUM_W'(PCT_DIV);
         if (rd_data_ff != '0) begin
            max_seen_in = 1'b1;
            max_idx_in  = s1_idx_ff;
         end
      end

      for (int k = 0; k < N_PCT; k++) begin
         pt_in[k]    = pt_ff[k];
         found_in[k] = found_ff[k];
         edge_in[k]  = edge_ff[k];
         if (cmd.start) begin
            pt_in[k]    = SUM_W'(total_ff) * SUM_W'(PCT_VALUE[k]);
            found_in[k] = 1'b0;
            edge_in[k]  = '0;
         end else if (s2_valid_ff && !found_ff[k] && (cum_ff >= pt_ff[k])) begin
            found_in[k] = 1'b1;
            edge_in[k]  = lower_edge(s2_idx_ff);
         end
      end

      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      cum_ff      <= cum_in;
      max_seen_ff <= max_seen_in;
      max_idx_ff  <= max_idx_in;
      for (int k = 0; k < N_PCT; k++) begin
         pt_ff[k]    <= pt_in[k];
         found_ff[k] <= found_in[k];
         edge_ff[k]  <= edge_in[k];
      end
      if (cmd.post) begin
         median_ff    <= edge_ff[0];
         p95_ff       <= edge_ff[1];
         p99_ff       <= edge_ff[2];
         max_bound_ff <= max_seen_ff ? upper_edge(max_idx_ff) : '0;
         no_events_ff <= (total_ff == '0);
      end
   end

   assign sts.last_issue = (CNT_W'(addr_ff) + CNT_W'(1)) == cnt_ff;
   assign sts.busy       = s1_valid_ff | s2_valid_ff;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median_edge = median_ff;
   assign rsp_p95_edge    = p95_ff;
   assign rsp_p99_edge    = p99_ff;
   assign rsp_max_bound   = max_bound_ff;
   assign rsp_no_events   = no_events_ff;

endmodule
